// ===== rtl/snsu_pkg.sv =====
package snsu_pkg;

  // Table geometry.
  localparam int unsigned NODE_COUNT = 1024;
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);

  // Divider geometry: dividend is |visits * delta|, divisor is at most n + visits.
  localparam int unsigned DVD_W = 41;
  localparam int unsigned DVS_W = 33;
  localparam int unsigned CNT_W = $clog2(DVD_W);

  // Request modes.
  localparam logic [2:0] MODE_START    = 3'd0;
  localparam logic [2:0] MODE_CANCEL   = 3'd1;
  localparam logic [2:0] MODE_FINALIZE = 3'd2;
  localparam logic [2:0] MODE_ADJUST   = 3'd3;
  localparam logic [2:0] MODE_MAKETERM = 3'd4;
  localparam logic [2:0] MODE_TRIM     = 3'd5;
  localparam logic [2:0] MODE_READ     = 3'd6;
  localparam logic [2:0] MODE_SPARE    = 3'd7;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_REFUSED   = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  // Game results.
  localparam logic [1:0] RES_LOSS = 2'd0;
  localparam logic [1:0] RES_DRAW = 2'd1;
  localparam logic [1:0] RES_WIN  = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic [9:0]         node_id;
    logic signed [15:0] value_wl;
    logic [15:0]        value_d;
    logic [23:0]        value_m;
    logic [15:0]        visits;
    logic [1:0]         game_result;
    logic [1:0]         terminal_kind;
  } snsu_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] mean_wl;
    logic [15:0]        mean_d;
    logic [23:0]        mean_m;
    logic [31:0]        visit_count;
    logic [15:0]        in_flight;
    logic [1:0]         terminal_state;
    logic [1:0]         bound_lo;
    logic [1:0]         bound_hi;
  } snsu_out_t;

  // One stored node entry.
  typedef struct packed {
    logic signed [15:0] wl;
    logic [15:0]        d;
    logic [23:0]        m;
    logic [31:0]        n;
    logic [15:0]        fl;
    logic [1:0]         term;
    logic [1:0]         lo;
    logic [1:0]         hi;
  } snsu_entry_t;

  localparam snsu_entry_t ENTRY_RESET = '{
    wl: 16'sd0, d: 16'd0, m: 24'd0, n: 32'd0, fl: 16'd0,
    term: 2'd0, lo: RES_LOSS, hi: RES_WIN
  };

endpackage

// ===== rtl/snsu_mem.sv =====
module snsu_mem
  import snsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  snsu_entry_t      wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output snsu_entry_t      rdata_o
);

  snsu_entry_t mem_q [NODE_COUNT];
  snsu_entry_t rdata_q;

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/snsu_div.sv =====
module snsu_div
  import snsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;

  // One restoring step per cycle: shift in a dividend bit, trial subtract.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    rem_sh  = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub;
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/search_node_stats_update.sv =====
// Node statistics update engine.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one request naming
// a node and a mode; the output channel (out_valid_o / out_ready_i /
// out_data_o) returns exactly one result per request: a status and the entry
// contents after the update.
// Requests are handled one at a time; in_ready_o is high only while idle.
// Start, cancel, make-terminal, trim and read pass through the read, execute
// and write-back states to the result. Finalize and adjust-terminal run three
// divisions (one per mean) through a shared bit-serial divider, each after a
// multiply and a start step, unless the divisor is zero or adjust underflows.
// The divider sets the rate. After reset the table is cleared by a pass over
// all 1024 entries, one entry per cycle, before the first request is accepted.
// When the receiver stalls, the finished result is held in the output
// register and the next request is accepted; its write-back then waits until
// the previous result has been taken.
module search_node_stats_update
  import snsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  snsu_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output snsu_out_t out_data_o
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_EXE  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_DIVS = 3'd5;
  localparam logic [2:0] ST_DIVW = 3'd6;
  localparam logic [2:0] ST_WB   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [IDX_W:0]   clr_q, clr_d;
  logic [1:0]       fld_q, fld_d;
  logic             ovalid_q, ovalid_d;
  snsu_in_t         req_q, req_d;
  snsu_entry_t      ent_q, ent_d;
  logic [1:0]       stat_q, stat_d;
  logic [DVS_W-1:0] den_q, den_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic             neg_q, neg_d;
  snsu_out_t        odata_q, odata_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  snsu_entry_t      mem_wdata;
  snsu_entry_t      rdata;
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] quotient;

  logic [24:0]         mean_ext;
  logic [24:0]         val_ext;
  logic signed [25:0]  mult_op;
  logic signed [42:0]  prod;
  logic [42:0]         prod_mag;
  logic signed [26:0]  qs;
  logic signed [26:0]  sum;
  logic [32:0]         nn;
  logic [1:0]          res;

  snsu_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (req_q.node_id[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  snsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Select the mean and sample of the field under work, widened to 25 bits.
  always_comb begin
    case (fld_q)
      2'd0: begin
        mean_ext = {{9{ent_q.wl[15]}}, ent_q.wl};
        val_ext  = {{9{req_q.value_wl[15]}}, req_q.value_wl};
      end
      2'd1: begin
        mean_ext = {9'd0, ent_q.d};
        val_ext  = {9'd0, req_q.value_d};
      end
      default: begin
        mean_ext = {1'b0, ent_q.m};
        val_ext  = {1'b0, req_q.value_m};
      end
    endcase
  end

  // Weighted numerator and its magnitude for the unsigned divider.
  always_comb begin
    if (req_q.mode == MODE_FINALIZE) begin
      mult_op = $signed({val_ext[24], val_ext}) - $signed({mean_ext[24], mean_ext});
    end else begin
      mult_op = $signed({val_ext[24], val_ext});
    end
    prod     = $signed({1'b0, req_q.visits}) * mult_op;
    prod_mag = prod[42] ? (43'd0 - prod) : prod;
    qs       = $signed({2'b00, quotient[24:0]});
    sum      = $signed({{2{mean_ext[24]}}, mean_ext}) + (neg_q ? -qs : qs);
  end

  assign nn  = {1'b0, rdata.n} + {17'd0, req_q.visits};
  assign res = (req_q.game_result == 2'd3) ? RES_WIN : req_q.game_result;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    fld_d     = fld_q;
    ovalid_d  = ovalid_q;
    req_d     = req_q;
    ent_d     = ent_q;
    stat_d    = stat_q;
    den_d     = den_q;
    dvd_d     = dvd_q;
    neg_d     = neg_q;
    odata_d   = odata_q;
    mem_we    = 1'b0;
    mem_waddr = req_q.node_id[IDX_W-1:0];
    mem_wdata = ent_q;
    div_start = 1'b0;
    in_ready_o = (state_q == ST_IDLE);

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q[IDX_W-1:0];
        mem_wdata = ENTRY_RESET;
        clr_d     = clr_q + 1'b1;
        if (clr_q == (IDX_W+1)'(NODE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_EXE;
      end
      ST_EXE: begin
        ent_d   = rdata;
        stat_d  = STAT_OK;
        fld_d   = 2'd0;
        state_d = ST_WB;
        unique case (req_q.mode)
          MODE_START: begin
            if (rdata.n != 32'd0) begin
              if (rdata.fl != 16'hFFFF) ent_d.fl = rdata.fl + 16'd1;
            end else if (rdata.fl == 16'd0) begin
              ent_d.fl = 16'd1;
            end else begin
              stat_d = STAT_REFUSED;
            end
          end
          MODE_CANCEL: begin
            if ({16'd0, req_q.visits} > {16'd0, rdata.fl}) begin
              ent_d.fl = 16'd0;
              stat_d   = STAT_UNDERFLOW;
            end else begin
              ent_d.fl = rdata.fl - req_q.visits;
            end
          end
          MODE_FINALIZE: begin
            ent_d.n = nn[32] ? 32'hFFFF_FFFF : nn[31:0];
            if (req_q.visits > rdata.fl) begin
              ent_d.fl = 16'd0;
              stat_d   = STAT_UNDERFLOW;
            end else begin
              ent_d.fl = rdata.fl - req_q.visits;
            end
            den_d = nn;
            if (nn != 33'd0) state_d = ST_MUL;
          end
          MODE_ADJUST: begin
            den_d = {1'b0, rdata.n};
            if ({16'd0, req_q.visits} > rdata.n) begin
              stat_d = STAT_UNDERFLOW;
            end else if (rdata.n != 32'd0) begin
              state_d = ST_MUL;
            end
          end
          MODE_MAKETERM: begin
            ent_d.lo   = res;
            ent_d.hi   = res;
            ent_d.term = req_q.terminal_kind;
            ent_d.m    = req_q.value_m;
            if (res == RES_DRAW) begin
              ent_d.wl = 16'sd0;
              ent_d.d  = 16'hFFFF;
            end else if (res == RES_WIN) begin
              ent_d.wl = 16'sh7FFF;
              ent_d.d  = 16'd0;
            end else begin
              ent_d.wl = -16'sh8000;
              ent_d.d  = 16'd0;
            end
          end
          MODE_TRIM: begin
            ent_d = ENTRY_RESET;
          end
          default: begin
          end
        endcase
      end
      ST_MUL: begin
        neg_d   = prod[42];
        dvd_d   = prod_mag[DVD_W-1:0];
        state_d = ST_DIVS;
      end
      ST_DIVS: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          // Clamp the updated mean to its field's range.
          case (fld_q)
            2'd0: begin
              if (sum > 27'sd32767) ent_d.wl = 16'sh7FFF;
              else if (sum < -27'sd32768) ent_d.wl = -16'sh8000;
              else ent_d.wl = sum[15:0];
            end
            2'd1: begin
              if (sum < 27'sd0) ent_d.d = 16'd0;
              else if (sum > 27'sd65535) ent_d.d = 16'hFFFF;
              else ent_d.d = sum[15:0];
            end
            default: begin
              if (sum < 27'sd0) ent_d.m = 24'd0;
              else if (sum > 27'sd16777215) ent_d.m = 24'hFFFFFF;
              else ent_d.m = sum[23:0];
            end
          endcase
          if (fld_q == 2'd2) begin
            state_d = ST_WB;
          end else begin
            fld_d   = fld_q + 2'd1;
            state_d = ST_MUL;
          end
        end
      end
      ST_WB: begin
        // Write back and publish once the output register is free.
        if (!ovalid_q || out_ready_i) begin
          mem_we   = 1'b1;
          ovalid_d = 1'b1;
          odata_d  = '{
            status: stat_q, mean_wl: ent_q.wl, mean_d: ent_q.d, mean_m: ent_q.m,
            visit_count: ent_q.n, in_flight: ent_q.fl, terminal_state: ent_q.term,
            bound_lo: ent_q.lo, bound_hi: ent_q.hi
          };
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      clr_q    <= '0;
      fld_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      fld_q    <= fld_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ent_q   <= ent_d;
    stat_q  <= stat_d;
    den_q   <= den_d;
    dvd_q   <= dvd_d;
    neg_q   <= neg_d;
    odata_q <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule
